>>> design/ffa_pkg.sv
// Package with the shared types and constants of the first-fit block allocator.
`timescale 1ns / 1ps

package ffa_pkg;

   // Default number of blocks in the free map and the largest supported count.
   localparam int NUM_BLOCKS_DEFAULT = 256;
   localparam int MAX_BLOCKS         = 4096;

   // Field widths of the channels.
   localparam int CFG_W   = 9;
   localparam int START_W = 8;
   localparam int LEN_W   = 9;
   localparam int STAT_W  = 2;

   // Width of block positions and range bounds, wide enough for any supported map.
   localparam int CNT_W = $clog2(MAX_BLOCKS) + 1;

   // Request codes.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD      = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_FINISH
   } state_type;

   // Command from the controller to the row of map cells.
   typedef struct packed {
      logic             shift;   // rotate the map one place toward cell 0
      logic             apply;   // write value into every cell of [lo, hi)
      logic             value;   // 1 marks free, 0 marks used
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
   } ring_cmd_type;

endpackage

>>> design/ffa_if.sv
// Channel interfaces of the first-fit block allocator.
`timescale 1ns / 1ps

// Request channel: one word per allocate or free request.
interface ffa_req_if import ffa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [START_W-1:0] run_start;
   logic [LEN_W-1:0]   run_length;

   modport source (output valid, output action, output run_start, output run_length,
                   input ready);
   modport sink   (input valid, input action, input run_start, input run_length,
                   output ready);
endinterface

// Result channel: one word per request.
interface ffa_rsp_if import ffa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [START_W-1:0] granted_start;

   modport source (output valid, output status, output granted_start, input ready);
   modport sink   (input valid, input status, input granted_start, output ready);
endinterface

// Register write channel: one word sets the managed block count.
interface ffa_csr_if import ffa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] blocks_in_use;

   modport source (output valid, output blocks_in_use, input ready);
   modport sink   (input valid, input blocks_in_use, output ready);
endinterface

>>> design/ffa_cell.sv
// One cell of the free map: holds the free bit of a single block position.
`timescale 1ns / 1ps

module ffa_cell import ffa_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  ring_cmd_type cmd,
   input  logic         neighbor_bit,
   output logic         free_bit
);

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic free_ff;
   logic free_in;
   logic in_range;

   // A range write hits this cell when its position lies in [lo, hi).
   assign in_range = (MY_POS >= cmd.lo) && (MY_POS < cmd.hi);

   always_comb begin
      free_in = free_ff;
      if (cmd.apply && in_range) begin
         free_in = cmd.value;
      end else if (cmd.shift) begin
         free_in = neighbor_bit;
      end
   end

   // Every block is free after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b1;
      end else begin
         free_ff <= free_in;
      end
   end

   assign free_bit = free_ff;

endmodule

>>> design/ffa_ring.sv
// Row of free-map cells closed into a ring; cell 0 is presented to the scanner.
`timescale 1ns / 1ps

module ffa_ring import ffa_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  ring_cmd_type cmd,
   output logic         head_bit
);

   logic [NUM_BLOCKS-1:0] cell_bit;

   // Each cell takes its upper neighbor's bit on a shift; the top cell takes cell 0.
   for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      localparam int NEXT = (k + 1) % NUM_BLOCKS;
      ffa_cell #(
         .INDEX (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .neighbor_bit (cell_bit[NEXT]),
         .free_bit     (cell_bit[k])
      );
   end

   assign head_bit = cell_bit[0];

endmodule

>>> design/ffa_ctrl.sv
// Request sequencer: checks requests, runs the first-fit scan and drives the result word.
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   ffa_req_if.sink          req,
   ffa_rsp_if.source        rsp,
   input  logic [CFG_W-1:0] blocks_in_use,
   input  logic             head_bit,
   output ring_cmd_type     cmd
);

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam logic [IW-1:0]    LAST_POS = IW'(NUM_BLOCKS - 1);
   localparam logic [CNT_W-1:0] MAP_SIZE = CNT_W'(NUM_BLOCKS);

   state_type           state_ff, state_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [IW-1:0]       begin_ff, begin_in;
   logic                found_ff, found_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic                val_ff, val_in;
   status_type          status_ff, status_in;
   logic [START_W-1:0]  grant_ff, grant_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;

   logic [CNT_W-1:0]    limit;
   logic [CNT_W-1:0]    free_end;
   logic [CNT_W-1:0]    begin_ext;
   logic                in_managed;
   logic                out_free;

   // Managed block count, clipped to the map size.
   assign limit = (CNT_W'(blocks_in_use) > MAP_SIZE) ? MAP_SIZE : CNT_W'(blocks_in_use);
   assign free_end = CNT_W'(req.run_start) + CNT_W'(req.run_length);
   assign in_managed = CNT_W'(idx_ff) < limit;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      begin_in      = begin_ff;
      found_in      = found_ff;
      len_in        = len_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      begin_ext     = CNT_W'(begin_ff);
      req.ready     = 1'b0;
      cmd.shift     = 1'b0;
      cmd.apply     = 1'b0;
      cmd.value     = val_ff;
      cmd.lo        = lo_ff;
      cmd.hi        = hi_ff;

      case (state_ff)
         // Take a request and sort it into bad, free or allocate.
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               len_in   = req.run_length;
               grant_in = '0;
               if (req.run_length == '0) begin
                  status_in = ST_BAD;
                  state_in  = S_FINISH;
               end else if (req.action == ACT_FREE) begin
                  if (free_end > limit) begin
                     status_in = ST_BAD;
                     state_in  = S_FINISH;
                  end else begin
                     lo_in     = CNT_W'(req.run_start);
                     hi_in     = free_end;
                     val_in    = 1'b1;
                     status_in = ST_OK;
                     state_in  = S_APPLY;
                  end
               end else begin
                  idx_in   = '0;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end

         // One block a cycle passes cell 0; the whole ring turns once.
         S_SCAN: begin
            cmd.shift = 1'b1;
            if (!found_ff && in_managed) begin
               if (head_bit) begin
                  if (cnt_ff == '0) begin
                     begin_in = idx_ff;
                  end
                  cnt_in = cnt_ff + LEN_W'(1);
                  if (cnt_in == len_ff) begin
                     found_in = 1'b1;
                  end
               end else begin
                  cnt_in = '0;
               end
            end
            idx_in = idx_ff + IW'(1);
            if (idx_ff == LAST_POS) begin
               idx_in    = '0;
               begin_ext = CNT_W'(begin_in);
               if (found_in) begin
                  lo_in     = begin_ext;
                  hi_in     = begin_ext + CNT_W'(len_ff);
                  val_in    = 1'b0;
                  status_in = ST_OK;
                  grant_in  = begin_ext[START_W-1:0];
                  state_in  = S_APPLY;
               end else begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_FINISH;
               end
            end
         end

         // Map is back in place: write the whole run as one range write.
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FINISH;
         end

         // Hand the result to the output register once it has room.
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = grant_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan bookkeeping and result payload.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      begin_ff      <= begin_in;
      found_ff      <= found_in;
      len_ff        <= len_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.granted_start = rsp_start_ff;

endmodule

>>> design/contiguous_first_fit_allocator.sv
// Top level of the first-fit contiguous block allocator.
`timescale 1ns / 1ps

// Usage:
// The free map holds one bit per block in a ring of cells; every block is free
// after reset, and the managed block count resets to 256.
// req_bus carries one request word: action (0 allocate, 1 free), run_start and
// run_length. rsp_bus returns one word per request: status (0 ok, 1 no space,
// 2 bad request) and granted_start, which is zero unless an allocate succeeded.
// csr_bus writes the managed block count; write it only while no request is open.
// A request with a zero length or a free range past the managed blocks goes
// straight to the result; a valid free first writes its range; an allocate first
// rotates the whole map through cell 0 one block per cycle so the scanner sees
// every block in order, then writes the run if it found one.
// One request is worked on at a time; the next one is taken as soon as the
// previous result sits in the output register.
// If the receiver stalls, the result stays in the output register, and a
// finished second request waits inside the block until that register drains.
// Reset is synchronous and active high.
module contiguous_first_fit_allocator import ffa_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ffa_req_if.sink   req_bus,
   ffa_rsp_if.source rsp_bus,
   ffa_csr_if.sink   csr_bus
);

   logic [CFG_W-1:0] blocks_in_use_ff;
   logic [CFG_W-1:0] blocks_in_use_in;
   ring_cmd_type     ring_cmd;
   logic             head_bit;

   // Managed block count register; writes are always taken.
   assign csr_bus.ready = 1'b1;
   assign blocks_in_use_in = csr_bus.valid ? csr_bus.blocks_in_use : blocks_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= CFG_W'(256);
      end else begin
         blocks_in_use_ff <= blocks_in_use_in;
      end
   end

   // Sequencer.
   ffa_ctrl #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .blocks_in_use (blocks_in_use_ff),
      .head_bit      (head_bit),
      .cmd           (ring_cmd)
   );

   // Free map.
   ffa_ring #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ring_cmd),
      .head_bit (head_bit)
   );

   // The map never rotates and takes a range write in the same cycle.
   a_no_shift_and_apply: assert property (@(posedge clock) disable iff (reset)
      !(ring_cmd.shift && ring_cmd.apply))
      else $error("ring rotated during a range write");

   // Once a request is taken, no other is taken in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while another is open");

   // A result with a status other than ok never reports a granted start.
   a_grant_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != ST_OK)) |-> (rsp_bus.granted_start == '0))
      else $error("granted start set on a failed result");

   // No result is shown in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

endmodule

>>> tb/sv/contiguous_first_fit_allocator_test.sv
// Self-checking testbench for the first-fit contiguous block allocator.
`timescale 1ns / 1ps

module contiguous_first_fit_allocator_test;
   import ffa_pkg::*;

   localparam int BLOCKS         = NUM_BLOCKS_DEFAULT;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   // One reply word as the allocator should return it.
   typedef struct {
      status_type         status;
      logic [START_W-1:0] granted_start;
   } alloc_reply_type;

   // A run that the allocator has handed out and that has not been freed yet.
   typedef struct {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
   } block_run_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffa_req_if req_bus ();
   ffa_rsp_if rsp_bus ();
   ffa_csr_if csr_bus ();

   contiguous_first_fit_allocator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the free map and of the managed block count.
   logic [BLOCKS-1:0] block_free      = '1;
   logic [CFG_W-1:0]  block_count_reg = CFG_W'(256);

   alloc_reply_type predicted_replies[$];
   block_run_type   held_runs[$];
   int              error_count  = 0;
   int              quiet_cycles = 0;
   bit              req_steady   = 1'b0;
   bit              rsp_steady   = 1'b0;
   bit              hold_results = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Works out the reply of one request and updates the shadow free map.
   function automatic alloc_reply_type request_outcome(input logic act,
                                                       input logic [START_W-1:0] start,
                                                       input logic [LEN_W-1:0] len);
      alloc_reply_type r;
      int              limit;
      int              run_begin;
      int              run_count;
      int              i;
      bit              found;
      limit         = (block_count_reg > BLOCKS) ? BLOCKS : int'(block_count_reg);
      r.status        = ST_BAD;
      r.granted_start = '0;
      run_begin     = 0;
      run_count     = 0;
      found         = 1'b0;
      if (len == 0) begin
         r.status = ST_BAD;
      end else if (act == ACT_ALLOC) begin
         // First fit: walk up from block 0 and stop at the first long enough run.
         for (i = 0; i < limit && !found; i++) begin
            if (block_free[i]) begin
               if (run_count == 0) run_begin = i;
               run_count++;
               if (run_count == int'(len)) found = 1'b1;
            end else begin
               run_count = 0;
            end
         end
         if (found) begin
            for (i = run_begin; i < run_begin + int'(len); i++) block_free[i] = 1'b0;
            r.status        = ST_OK;
            r.granted_start = START_W'(run_begin);
         end else begin
            r.status = ST_NO_SPACE;
         end
      end else begin
         if (int'(start) + int'(len) > limit) begin
            r.status = ST_BAD;
         end else begin
            for (i = int'(start); i < int'(start) + int'(len); i++) block_free[i] = 1'b1;
            r.status = ST_OK;
         end
      end
      return r;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 88) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // Allocation lengths lean small so that the map churns, with a few large ones.
   function automatic logic [LEN_W-1:0] draw_alloc_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return LEN_W'($urandom_range(1, 8));
      if (p < 90) return LEN_W'($urandom_range(9, 40));
      if (p < 97) return LEN_W'($urandom_range(41, 128));
      return LEN_W'($urandom_range(129, 256));
   endfunction

   // Offers one request word and records its expected reply once it is taken.
   task automatic send_request(input logic act, input logic [START_W-1:0] start,
                               input logic [LEN_W-1:0] len);
      int              gap;
      alloc_reply_type want;
      block_run_type   run;
      gap = req_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.run_start  <= start;
      req_bus.run_length <= len;
      do @(posedge clock); while (!req_bus.ready);
      want = request_outcome(act, start, len);
      predicted_replies.push_back(want);
      if (act == ACT_ALLOC && want.status == ST_OK) begin
         run.start  = want.granted_start;
         run.length = len;
         held_runs.push_back(run);
      end
   endtask

   // Stops offering requests and waits until every reply has come back.
   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the managed block count while the allocator is idle.
   task automatic write_block_count(input logic [CFG_W-1:0] value);
      wait_for_replies();
      csr_bus.valid         <= 1'b1;
      csr_bus.blocks_in_use <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid   <= 1'b0;
      block_count_reg = value;
   endtask

   // Frees the whole map at full size, then sets the count for the next phase.
   task automatic restart_phase(input logic [CFG_W-1:0] value);
      write_block_count(CFG_W'(256));
      send_request(ACT_FREE, '0, LEN_W'(256));
      write_block_count(value);
      held_runs.delete();
   endtask

   // Field extremes and the corner cases, all at the reset block count.
   task automatic test_directed_cases();
      send_request(ACT_ALLOC, '0, '0);             // zero length allocate
      send_request(ACT_FREE, 8'd5, '0);            // zero length free
      send_request(ACT_ALLOC, 8'd200, 9'd1);       // start is ignored on allocate
      send_request(ACT_ALLOC, '0, 9'd3);
      send_request(ACT_FREE, '0, 9'd1);            // leaves a one-block hole at 0
      send_request(ACT_ALLOC, '0, 9'd2);           // must skip the hole
      send_request(ACT_ALLOC, '0, 9'd1);           // fills the hole
      send_request(ACT_FREE, 8'd255, 9'd2);        // free past the end
      send_request(ACT_FREE, 8'd250, 9'd6);        // freeing blocks that are free
      send_request(ACT_ALLOC, '0, 9'd257);         // longer than the map
      send_request(ACT_ALLOC, 8'hff, 9'd511);
      send_request(ACT_FREE, 8'd1, 9'd5);
      send_request(ACT_FREE, '0, 9'd256);
      send_request(ACT_ALLOC, '0, 9'd256);         // the whole map in one run
      send_request(ACT_ALLOC, '0, 9'd1);           // map is full
      send_request(ACT_FREE, 8'd128, 9'd128);
      send_request(ACT_FREE, 8'd255, 9'd1);
      send_request(ACT_FREE, '0, 9'd511);
      send_request(ACT_ALLOC, '0, 9'd128);
      send_request(ACT_FREE, '0, 9'd256);
      wait_for_replies();
   endtask

   // Mostly frees of runs that were granted, allocations, and some malformed words.
   task automatic test_random_traffic(input int count);
      int            n;
      int            pick;
      int            idx;
      block_run_type run;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 42 && held_runs.size() > 0) begin
            idx = $urandom_range(0, held_runs.size() - 1);
            run = held_runs[idx];
            held_runs.delete(idx);
            send_request(ACT_FREE, run.start, run.length);
         end else if (pick < 90) begin
            send_request(ACT_ALLOC, START_W'($urandom), draw_alloc_length());
         end else if (pick < 95) begin
            send_request($urandom_range(0, 1) ? ACT_FREE : ACT_ALLOC, START_W'($urandom),
                         LEN_W'($urandom_range(0, 40)));
         end else begin
            send_request($urandom_range(0, 1) ? ACT_FREE : ACT_ALLOC, START_W'($urandom),
                         LEN_W'($urandom));
         end
      end
   endtask

   // Sweeps the block count through its extremes and values past the map size.
   task automatic test_block_count_settings();
      logic [CFG_W-1:0] settings[7] = '{9'd1, 9'd0, 9'd2, 9'd511, 9'd300, 9'd100, 9'd256};
      int               k;
      for (k = 0; k < 7; k++) begin
         restart_phase(settings[k]);
         test_random_traffic(40);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_result_backpressure();
      int n;
      req_steady   = 1'b1;
      hold_results = 1'b1;
      for (n = 0; n < 10; n++) begin
         send_request(n[0] ? ACT_FREE : ACT_ALLOC, START_W'(n), LEN_W'(n % 3));
      end
      req_steady = 1'b0;
      wait_for_replies();
   endtask

   // A stretch with no idling on either side.
   task automatic test_steady_stream();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      test_random_traffic(100);
      wait_for_replies();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // Result side: random ready, the long hold-off on request, and the checks.
   initial begin : reply_checker
      int              idle_left;
      alloc_reply_type want;
      idle_left     = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_replies.size() == 0) begin
               $error("reply word with no request waiting: status %0d, granted_start %0d",
                      rsp_bus.status, rsp_bus.granted_start);
               error_count++;
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status,
                         rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.granted_start !== want.granted_start) begin
                  $error("granted_start mismatch: expected %0d, got %0d",
                         want.granted_start, rsp_bus.granted_start);
                  error_count++;
               end
            end
            if (!rsp_steady) idle_left = idle_gap();
         end else if (!rsp_steady && idle_left == 0 && $urandom_range(0, 99) < 4) begin
            idle_left = idle_gap();
         end
         if (hold_results) begin
            hold_results = 1'b0;
            idle_left    = LONG_HOLD;
         end
         if (idle_left > 0) begin
            rsp_bus.ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Ends the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin : test_sequence
      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_ALLOC;
      req_bus.run_start     <= '0;
      req_bus.run_length    <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.blocks_in_use <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_result_backpressure();
      test_block_count_settings();
      restart_phase(CFG_W'(256));
      test_random_traffic(400);
      restart_phase(CFG_W'(64));
      test_random_traffic(250);
      restart_phase(CFG_W'($urandom_range(1, 256)));
      test_random_traffic(200);
      restart_phase(CFG_W'(256));
      test_steady_stream();

      wait_for_replies();
      repeat (BLOCKS + 40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ffa_pkg.sv
design/ffa_if.sv
design/ffa_cell.sv
design/ffa_ring.sv
design/ffa_ctrl.sv
design/contiguous_first_fit_allocator.sv
tb/sv/contiguous_first_fit_allocator_test.sv
